FILE: design/twi_slave_packet_engine_defines.svh
// Assertion macros for the TWI slave packet engine.
`ifndef TWI_SLAVE_PACKET_ENGINE_DEFINES_SVH
`define TWI_SLAVE_PACKET_ENGINE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define TSPE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tspe same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define TSPE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tspe next-cycle check failed");

`endif

FILE: design/tspe_pkg.sv
// Types and constants shared by the TWI slave packet engine.
package tspe_pkg;

  localparam int DEF_PACKET_BYTES = 5;
  localparam int HOST_IDX_SPAN    = 8;  // positions reachable by a 3-bit buf_index

  typedef enum logic [2:0] {
    OP_BUS_EVENT = 3'd0,
    OP_ARM_SEND  = 3'd1,
    OP_ARM_RECV  = 3'd2,
    OP_SKIP_IN   = 3'd3,
    OP_LOAD_TX   = 3'd4,
    OP_READ_RX   = 3'd5
  } op_t;

  localparam logic [7:0] CODE_BUS_ERROR = 8'h00;
  localparam logic [7:0] CODE_SLA_W     = 8'h60;
  localparam logic [7:0] CODE_SLA_W_ARB = 8'h68;
  localparam logic [7:0] CODE_RX_DATA   = 8'h80;
  localparam logic [7:0] CODE_RX_NACK   = 8'h88;
  localparam logic [7:0] CODE_RX_STOP   = 8'hA0;
  localparam logic [7:0] CODE_SLA_R     = 8'hA8;
  localparam logic [7:0] CODE_SLA_R_ARB = 8'hB0;
  localparam logic [7:0] CODE_TX_DATA   = 8'hB8;
  localparam logic [7:0] CODE_TX_NACK   = 8'hC0;
  localparam logic [7:0] CODE_TX_LAST   = 8'hC8;
  localparam logic [7:0] STATE_IDLE     = 8'hFF;
  localparam logic [7:0] STATE_PENDING  = 8'h00;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] bus_status;
    logic [7:0] rx_byte;
    logic [2:0] buf_index;
    logic [7:0] buf_value;
  } item_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic       ack_enable;
    logic       stop_recover;
    logic       hold_bus;
    logic [7:0] rx_status;
    logic [7:0] tx_status;
  } result_t;

endpackage

FILE: design/tspe_core.sv
// Packet buffers, pointers and transfer state; decodes one item per cycle, committing it only while commit is high.
module tspe_core import tspe_pkg::*; #(
  parameter int PACKET_BYTES = DEF_PACKET_BYTES
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    commit,
  input  item_t   item,
  output result_t res
);

  localparam int POS_W       = $clog2(PACKET_BYTES + 1);
  localparam int STORE_DEPTH = (PACKET_BYTES < HOST_IDX_SPAN) ? PACKET_BYTES : HOST_IDX_SPAN;
  localparam int SEL_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam bit LAST_STORED = (PACKET_BYTES <= HOST_IDX_SPAN);
  localparam logic [POS_W-1:0] POS_FULL = POS_W'(PACKET_BYTES);

  // only host-addressable positions are kept; the rest always read as zero
  logic [7:0]       out_mem_r [STORE_DEPTH];
  logic [7:0]       in_mem_r  [STORE_DEPTH];
  logic [POS_W-1:0] out_pos_r, out_pos_nxt;
  logic [POS_W-1:0] in_pos_r, in_pos_nxt;
  logic [7:0]       out_state_r, out_state_nxt;
  logic [7:0]       in_state_r, in_state_nxt;

  logic             out_we, in_we, in_last_we;
  logic [SEL_W-1:0] out_wsel, in_wsel;
  logic [7:0]       out_wdata, in_wdata;
  logic             idx_ok;
  logic [POS_W-1:0] in_pos_inc;

  assign idx_ok     = 32'(item.buf_index) < 32'(PACKET_BYTES);
  assign in_pos_inc = in_pos_r + POS_W'(1);

  always_comb begin
    out_pos_nxt   = out_pos_r;
    in_pos_nxt    = in_pos_r;
    out_state_nxt = out_state_r;
    in_state_nxt  = in_state_r;
    out_we        = 1'b0;
    in_we         = 1'b0;
    in_last_we    = 1'b0;
    out_wsel      = item.buf_index[SEL_W-1:0];
    out_wdata     = item.buf_value;
    in_wsel       = in_pos_r[SEL_W-1:0];
    in_wdata      = item.rx_byte;
    res           = '0;

    unique case (op_t'(item.op))
      OP_BUS_EVENT: begin
        unique case (item.bus_status) inside
          CODE_SLA_R, CODE_SLA_R_ARB, CODE_TX_DATA: begin
            if (out_pos_r < POS_FULL) begin
              if (32'(out_pos_r) < 32'(STORE_DEPTH)) begin
                res.tx_byte = out_mem_r[out_pos_r[SEL_W-1:0]];
              end
              out_pos_nxt = out_pos_r + POS_W'(1);
            end
            res.tx_valid   = 1'b1;
            res.ack_enable = 1'b1;
          end
          CODE_TX_NACK, CODE_TX_LAST: begin
            out_state_nxt  = item.bus_status;
            res.ack_enable = 1'b1;
          end
          CODE_SLA_W, CODE_SLA_W_ARB: begin
            res.ack_enable = in_pos_r < POS_FULL;
          end
          CODE_RX_DATA: begin
            if (in_pos_r < POS_FULL) begin
              in_we      = 32'(in_pos_r) < 32'(STORE_DEPTH);
              in_pos_nxt = in_pos_inc;
              if (in_pos_inc < POS_FULL) begin
                res.ack_enable = 1'b1;
              end else begin
                in_state_nxt = CODE_RX_DATA;
                res.hold_bus = 1'b1;
              end
            end else begin
              in_state_nxt = CODE_RX_DATA;
              res.hold_bus = 1'b1;
            end
          end
          CODE_RX_NACK, CODE_RX_STOP: begin
            in_state_nxt   = item.bus_status;
            res.ack_enable = 1'b1;
          end
          CODE_BUS_ERROR: begin
            res.ack_enable   = 1'b1;
            res.stop_recover = 1'b1;
            in_state_nxt     = STATE_IDLE;
            out_state_nxt    = STATE_IDLE;
          end
          default: begin
          end
        endcase
      end
      OP_ARM_SEND: begin
        out_state_nxt  = STATE_PENDING;
        out_pos_nxt    = '0;
        res.ack_enable = 1'b1;
      end
      OP_ARM_RECV: begin
        in_state_nxt   = STATE_PENDING;
        in_pos_nxt     = '0;
        in_last_we     = LAST_STORED;
        res.ack_enable = 1'b1;
      end
      OP_SKIP_IN: begin
        if (in_state_r != CODE_RX_STOP && in_state_r != STATE_IDLE) begin
          in_state_nxt   = STATE_PENDING;
          res.ack_enable = 1'b1;
        end
      end
      OP_LOAD_TX: begin
        out_we = idx_ok;
      end
      OP_READ_RX: begin
        if (idx_ok) begin
          res.tx_byte = in_mem_r[item.buf_index[SEL_W-1:0]];
        end
      end
      default: begin
      end
    endcase

    res.rx_status = in_state_nxt;
    res.tx_status = out_state_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_pos_r   <= POS_FULL;
      in_pos_r    <= POS_FULL;
      out_state_r <= STATE_IDLE;
      in_state_r  <= STATE_IDLE;
      for (int i = 0; i < STORE_DEPTH; i++) begin
        out_mem_r[i] <= '0;
        in_mem_r[i]  <= '0;
      end
    end else if (commit) begin
      out_pos_r   <= out_pos_nxt;
      in_pos_r    <= in_pos_nxt;
      out_state_r <= out_state_nxt;
      in_state_r  <= in_state_nxt;
      if (out_we) begin
        out_mem_r[out_wsel] <= out_wdata;
      end
      if (in_we) begin
        in_mem_r[in_wsel] <= in_wdata;
      end
      if (in_last_we) begin
        in_mem_r[SEL_W'(PACKET_BYTES - 1)] <= 8'hFF;
      end
    end
  end

endmodule

FILE: design/twi_slave_packet_engine.sv
// Top level of the TWI slave packet engine: input register, core, result register.
//
// Usage: each input transfer carries one operation (bus event, arm send, arm
// receive, skip input, load tx byte, read rx byte) and yields exactly one
// result transfer with the byte to drive, acknowledge/stop/hold controls and
// the receive and transmit status after the operation.
// Channels use valid/stall; a transfer happens when valid is high and stall
// is low. Payload fields are separate ports.
// Pipeline: an input transfer fills the input register; the core result is then
// captured in the result register, which drives the outputs until it transfers.
// Throughput: one item per cycle while results are not stalled, set by the
// single-pass decode and state update in the core.
// Stall: while out_stall holds a result, the input register keeps its item and
// in_stall rises only once that register is occupied; results keep order.
// Reset (rst_n low, synchronous): both statuses read 0xFF, nothing is armed,
// both packet buffers are zero and both pipeline registers are empty.
`include "twi_slave_packet_engine_defines.svh"

module twi_slave_packet_engine import tspe_pkg::*; #(
  parameter int PACKET_BYTES = DEF_PACKET_BYTES
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_op,
  input  logic [7:0] in_bus_status,
  input  logic [7:0] in_rx_byte,
  input  logic [2:0] in_buf_index,
  input  logic [7:0] in_buf_value,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_tx_byte,
  output logic       out_tx_valid,
  output logic       out_ack_enable,
  output logic       out_stop_recover,
  output logic       out_hold_bus,
  output logic [7:0] out_rx_status,
  output logic [7:0] out_tx_status
);

  logic    s1_valid_r;
  item_t   s1_item_r;
  logic    s1_adv;
  logic    out_valid_r;
  result_t out_res_r;
  result_t core_res;

  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item_r <= '{op: in_op, bus_status: in_bus_status, rx_byte: in_rx_byte,
                     buf_index: in_buf_index, buf_value: in_buf_value};
    end
  end

  tspe_core #(.PACKET_BYTES(PACKET_BYTES)) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .commit (s1_adv),
    .item   (s1_item_r),
    .res    (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res_r <= core_res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_tx_byte      = out_res_r.tx_byte;
  assign out_tx_valid     = out_res_r.tx_valid;
  assign out_ack_enable   = out_res_r.ack_enable;
  assign out_stop_recover = out_res_r.stop_recover;
  assign out_hold_bus     = out_res_r.hold_bus;
  assign out_rx_status    = out_res_r.rx_status;
  assign out_tx_status    = out_res_r.tx_status;

  `TSPE_ASSERT_NOW(a_stall_needs_item, clk, rst_n, in_stall, s1_valid_r && out_valid_r)
  `TSPE_ASSERT_NEXT(a_adv_fills_out, clk, rst_n, s1_adv, out_valid_r)
  `TSPE_ASSERT_NOW(a_hold_status, clk, rst_n, out_valid_r && out_hold_bus,
                   out_rx_status == CODE_RX_DATA && !out_ack_enable)
  `TSPE_ASSERT_NOW(a_stop_idles, clk, rst_n, out_valid_r && out_stop_recover,
                   out_rx_status == STATE_IDLE && out_tx_status == STATE_IDLE)

endmodule
